// ===== rtl/tlsm_pkg.sv =====
// Package for the tracking lock state machine.
// Holds the event and lock codes, the configuration and result structs.
// No dependencies.
package tlsm_pkg;

    // Event operation codes
    localparam logic [2:0] OP_VISIBILITY = 3'd0;
    localparam logic [2:0] OP_CONT_OK    = 3'd1;
    localparam logic [2:0] OP_CONT_FAIL  = 3'd2;
    localparam logic [2:0] OP_RECOG_OK   = 3'd3;
    localparam logic [2:0] OP_RECOG_FAIL = 3'd4;
    localparam logic [2:0] OP_RESTART    = 3'd5;
    localparam logic [2:0] OP_RESET      = 3'd6;
    localparam logic [2:0] OP_QUERY      = 3'd7;

    // Lock state codes
    localparam logic [2:0] LK_UNINIT     = 3'd0;
    localparam logic [2:0] LK_TRACKING   = 3'd1;
    localparam logic [2:0] LK_SUSPECT    = 3'd2;
    localparam logic [2:0] LK_RECOVERING = 3'd3;
    localparam logic [2:0] LK_HIDDEN     = 3'd4;

    // Configuration register indexes
    localparam logic [1:0] CFG_HOLD_TIME     = 2'd0;
    localparam logic [1:0] CFG_VISIBLE_NEED  = 2'd1;
    localparam logic [1:0] CFG_FAILURE_LIMIT = 2'd2;

    localparam logic [15:0] HOLD_TIME_RESET     = 16'd2000;
    localparam logic [3:0]  VISIBLE_NEED_RESET  = 4'd2;
    localparam logic [3:0]  FAILURE_LIMIT_RESET = 4'd3;

    localparam logic [3:0]  COUNT_MAX = 4'hF;
    localparam logic [15:0] BATCH_MAX = 16'hFFFF;

    typedef struct packed {
        logic [15:0] hold_time_ms;
        logic [3:0]  visible_frames_needed;
        logic [3:0]  failure_limit;
    } cfg_t;

    typedef struct packed {
        logic [15:0] failed_batch_count;
        logic        hide_markers;
        logic        trusted_usable;
        logic [2:0]  lock_code;
    } result_t;

endpackage

// ===== rtl/tracking_lock_state_machine.sv =====
// Top level of the tracking lock state machine: config registers,
// input register, result register. Depends on tlsm_pkg and tlsm_core.
//
//  channel   direction  handshake          payload
//  s_*       in         s_tvalid/s_tready  s_tdata: op, visible, now_ms
//  m_*       out        m_tvalid/m_tready  m_tdata: lock_code, usable, hide, count
//  cfg_*     in         cfg_wen            cfg_index, cfg_wdata
//
// Each event is held in the input register, then passes through the update
// logic into the result register; one event per cycle sustained while m_tready
// stays high. The update of the lock state and the 32-bit elapsed-time
// compare sit between those two registers.
// Reset clears the lock state and loads the config defaults (hold 2000 ms,
// two visible frames, three continuity failures).
// A stall on m_tready holds the result register; the input register takes one
// more transfer only if it is empty, and then s_tready drops.
module tracking_lock_state_machine
    import tlsm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // input event stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [2:0] op, [3] visible, [35:4] now_ms, [39:36] zero
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [2:0] lock_code, [3] trusted_usable,
                                   // [4] hide_markers, [20:5] failed_batch_count,
                                   // [23:21] zero
    // configuration write port
    input  logic        cfg_wen,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_wdata
);

    cfg_t        cfg_reg;
    logic        in_valid_reg;
    logic [2:0]  op_reg;
    logic        visible_reg;
    logic [31:0] now_ms_reg;
    logic        out_valid_reg;
    result_t     result_reg;
    result_t     result_next;
    logic        advance;

    // Advance the held event into the result register when that slot is free
    // or being emptied this cycle.
    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    // Config writes: drop any index past the register list.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hold_time_ms          <= HOLD_TIME_RESET;
            cfg_reg.visible_frames_needed <= VISIBLE_NEED_RESET;
            cfg_reg.failure_limit         <= FAILURE_LIMIT_RESET;
        end
        else if (cfg_wen)
        begin
            case (cfg_index)
                CFG_HOLD_TIME:     cfg_reg.hold_time_ms          <= cfg_wdata;
                CFG_VISIBLE_NEED:  cfg_reg.visible_frames_needed <= cfg_wdata[3:0];
                CFG_FAILURE_LIMIT: cfg_reg.failure_limit         <= cfg_wdata[3:0];
                default:
                begin
                end
            endcase
        end
    end

    // Input register: hold the event until it advances.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            op_reg      <= s_tdata[2:0];
            visible_reg <= s_tdata[3];
            now_ms_reg  <= s_tdata[35:4];
        end
    end

    tlsm_core u_core
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .op      (op_reg),
        .visible (visible_reg),
        .now_ms  (now_ms_reg),
        .cfg     (cfg_reg),
        .result  (result_next)
    );

    // Result register: load on advance, clear valid once the transfer is taken.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (advance)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            result_reg <= result_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, result_reg.failed_batch_count, result_reg.hide_markers,
                       result_reg.trusted_usable, result_reg.lock_code};

endmodule

// ===== rtl/tlsm_core.sv =====
// Lock state registers and the per-event update logic.
// Depends on tlsm_pkg for codes and the cfg_t / result_t structs.
module tlsm_core
    import tlsm_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          step,
    input  logic [2:0]    op,
    input  logic          visible,
    input  logic [31:0]   now_ms,
    input  cfg_t          cfg,
    output result_t       result
);

    logic [2:0]  lock_state_reg,     lock_state_next;
    logic [3:0]  visible_count_reg,  visible_count_next;
    logic [3:0]  failure_count_reg,  failure_count_next;
    logic [15:0] failed_batches_reg, failed_batches_next;
    logic        trusted_valid_reg,  trusted_valid_next;
    logic [31:0] trusted_time_reg,   trusted_time_next;

    logic [3:0]  vis_inc;
    logic [3:0]  fail_inc;
    logic [2:0]  vis_base;
    logic [31:0] elapsed;
    logic        usable;

    assign vis_inc  = (visible_count_reg < COUNT_MAX) ? visible_count_reg + 4'd1
                                                      : visible_count_reg;
    assign fail_inc = (failure_count_reg < COUNT_MAX) ? failure_count_reg + 4'd1
                                                      : failure_count_reg;
    // visible report in hidden falls back to uninitialized first
    assign vis_base = (lock_state_reg == LK_HIDDEN) ? LK_UNINIT : lock_state_reg;

    always_comb
    begin
        lock_state_next     = lock_state_reg;
        visible_count_next  = visible_count_reg;
        failure_count_next  = failure_count_reg;
        failed_batches_next = failed_batches_reg;
        trusted_valid_next  = trusted_valid_reg;
        trusted_time_next   = trusted_time_reg;
        case (op)
            OP_VISIBILITY:
            begin
                if (!visible)
                begin
                    lock_state_next    = LK_HIDDEN;
                    visible_count_next = 4'd0;
                end
                else if (vis_base == LK_UNINIT)
                begin
                    visible_count_next = vis_inc;
                    lock_state_next    = (vis_inc >= cfg.visible_frames_needed)
                                         ? LK_RECOVERING : LK_UNINIT;
                end
            end
            OP_CONT_OK, OP_RECOG_OK:
            begin
                lock_state_next     = LK_TRACKING;
                failure_count_next  = 4'd0;
                failed_batches_next = 16'd0;
                trusted_valid_next  = 1'b1;
                trusted_time_next   = now_ms;
            end
            OP_CONT_FAIL:
            begin
                if (lock_state_reg == LK_TRACKING)
                begin
                    failure_count_next = 4'd1;
                    lock_state_next    = LK_SUSPECT;
                end
                else if (lock_state_reg == LK_SUSPECT)
                begin
                    failure_count_next = fail_inc;
                    if (fail_inc >= cfg.failure_limit)
                        lock_state_next = LK_RECOVERING;
                end
            end
            OP_RECOG_FAIL:
            begin
                lock_state_next = LK_RECOVERING;
                if (failed_batches_reg < BATCH_MAX)
                    failed_batches_next = failed_batches_reg + 16'd1;
            end
            OP_RESTART:
            begin
                lock_state_next     = LK_RECOVERING;
                visible_count_next  = 4'd0;
                failure_count_next  = 4'd0;
                failed_batches_next = 16'd1;
                trusted_valid_next  = 1'b0;
                trusted_time_next   = 32'd0;
            end
            OP_RESET:
            begin
                lock_state_next     = LK_UNINIT;
                visible_count_next  = 4'd0;
                failure_count_next  = 4'd0;
                failed_batches_next = 16'd0;
                trusted_valid_next  = 1'b0;
                trusted_time_next   = 32'd0;
            end
            OP_QUERY:
            begin
            end
            default:
            begin
            end
        endcase
    end

    // wrapping elapsed time against the post-event trusted time
    assign elapsed = now_ms - trusted_time_next;
    assign usable  = trusted_valid_next && (lock_state_next != LK_HIDDEN)
                     && (elapsed <= {16'd0, cfg.hold_time_ms});

    always_comb
    begin
        result.lock_code          = lock_state_next;
        result.trusted_usable     = usable;
        result.failed_batch_count = failed_batches_next;
        if (lock_state_next == LK_HIDDEN)
            result.hide_markers = 1'b1;
        else if (lock_state_next inside {LK_SUSPECT, LK_RECOVERING})
            result.hide_markers = !usable;
        else
            result.hide_markers = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lock_state_reg     <= LK_UNINIT;
            visible_count_reg  <= 4'd0;
            failure_count_reg  <= 4'd0;
            failed_batches_reg <= 16'd0;
            trusted_valid_reg  <= 1'b0;
            trusted_time_reg   <= 32'd0;
        end
        else if (step)
        begin
            lock_state_reg     <= lock_state_next;
            visible_count_reg  <= visible_count_next;
            failure_count_reg  <= failure_count_next;
            failed_batches_reg <= failed_batches_next;
            trusted_valid_reg  <= trusted_valid_next;
            trusted_time_reg   <= trusted_time_next;
        end
    end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// Self-checking bench for tracking_lock_state_machine: directed walks, register extremes
// and random event traffic checked against a local lock tracker.
// Depends on tlsm_pkg and the RTL top level; nothing else.
module tb_top;
    import tlsm_pkg::*;

    localparam int WATCHDOG_LIMIT  = 1000;
    localparam int ITEMS_PER_PHASE = 170;
    localparam int RANDOM_PHASES   = 6;
    localparam int MAX_REPORTS     = 10;

    // one input event as it sits in s_tdata, highest field first
    typedef struct packed {
        logic [31:0] now_ms;
        logic        visible;
        logic [2:0]  op;
    } lock_event_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata   = '0;    // [2:0] op, [3] visible, [35:4] now_ms, [39:36] zero
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [23:0] m_tdata;           // [2:0] lock_code, [3] trusted_usable,
                                    // [4] hide_markers, [20:5] failed_batch_count
    logic        cfg_wen   = 1'b0;
    logic [1:0]  cfg_index = CFG_HOLD_TIME;
    logic [15:0] cfg_wdata = '0;

    // Local copy of the tracker: registers and lock state
    cfg_t        trk_cfg = '{hold_time_ms: HOLD_TIME_RESET,
                             visible_frames_needed: VISIBLE_NEED_RESET,
                             failure_limit: FAILURE_LIMIT_RESET};
    logic [2:0]  trk_state   = LK_UNINIT;
    logic [3:0]  vis_cnt     = '0;
    logic [3:0]  fail_cnt    = '0;
    logic [15:0] batch_cnt   = '0;
    logic        trust_valid = 1'b0;
    logic [31:0] trust_time  = '0;

    // lock reports predicted but not yet seen on the result stream
    result_t     lock_reports_due[$];

    int          mismatches      = 0;
    int          events_sent     = 0;
    int          reports_checked = 0;
    int          settings_loaded = 0;
    int          idle_cycles     = 0;
    int          stall_left      = 0;
    bit          steady          = 1'b0;    // no gaps on either side while set
    logic [4:0]  states_seen     = '0;
    logic [31:0] clock_ms        = '0;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    tracking_lock_state_machine dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wen   (cfg_wen),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // ------------------------------------------------------------------
    // Lock tracker prediction
    // ------------------------------------------------------------------
    function automatic void clear_tracker();
        trk_state   = LK_UNINIT;
        vis_cnt     = '0;
        fail_cnt    = '0;
        batch_cnt   = '0;
        trust_valid = 1'b0;
        trust_time  = '0;
    endfunction

    function automatic void count_failed_batch();
        trk_state = LK_RECOVERING;
        if (batch_cnt < BATCH_MAX)
            batch_cnt = batch_cnt + 16'd1;
    endfunction

    // Apply one event to the local tracker and return the report it must produce
    function automatic result_t advance_tracker(lock_event_t ev);
        logic [31:0] elapsed;
        result_t     rep;
        case (ev.op)
            OP_VISIBILITY:
            begin
                if (!ev.visible)
                begin
                    trk_state = LK_HIDDEN;
                    vis_cnt   = '0;
                end
                else
                begin
                    // target back in view: hidden falls to uninit, then counts frames
                    if (trk_state == LK_HIDDEN)
                        trk_state = LK_UNINIT;
                    if (trk_state == LK_UNINIT)
                    begin
                        if (vis_cnt < COUNT_MAX)
                            vis_cnt = vis_cnt + 4'd1;
                        if (vis_cnt >= trk_cfg.visible_frames_needed)
                            trk_state = LK_RECOVERING;
                    end
                end
            end
            OP_CONT_OK, OP_RECOG_OK:
            begin
                trk_state   = LK_TRACKING;
                fail_cnt    = '0;
                batch_cnt   = '0;
                trust_valid = 1'b1;
                trust_time  = ev.now_ms;
            end
            OP_CONT_FAIL:
            begin
                if (trk_state == LK_TRACKING)
                begin
                    fail_cnt  = 4'd1;
                    trk_state = LK_SUSPECT;
                end
                else if (trk_state == LK_SUSPECT)
                begin
                    if (fail_cnt < COUNT_MAX)
                        fail_cnt = fail_cnt + 4'd1;
                    if (fail_cnt >= trk_cfg.failure_limit)
                        trk_state = LK_RECOVERING;
                end
            end
            OP_RECOG_FAIL:
                count_failed_batch();
            OP_RESTART:
            begin
                clear_tracker();
                count_failed_batch();
            end
            OP_RESET:
                clear_tracker();
            default:
                ;
        endcase

        // elapsed time wraps modulo 2^32, so going backwards looks like a long wait
        elapsed = ev.now_ms - trust_time;
        rep.lock_code          = trk_state;
        rep.trusted_usable     = trust_valid && (trk_state != LK_HIDDEN) &&
                                 (elapsed <= {16'd0, trk_cfg.hold_time_ms});
        rep.hide_markers       = (trk_state == LK_HIDDEN) ||
                                 (((trk_state == LK_SUSPECT) || (trk_state == LK_RECOVERING)) &&
                                  !rep.trusted_usable);
        rep.failed_batch_count = batch_cnt;
        return rep;
    endfunction

    // ------------------------------------------------------------------
    // Result checking, prediction on input transfers, receiver stalls
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        result_t     got;
        result_t     want;
        lock_event_t ev;
        int          pick;
        if (rst_n)
        begin
            // track register writes; they only come while the block is idle
            if (cfg_wen)
            begin
                case (cfg_index)
                    CFG_HOLD_TIME:     trk_cfg.hold_time_ms          = cfg_wdata;
                    CFG_VISIBLE_NEED:  trk_cfg.visible_frames_needed = cfg_wdata[3:0];
                    CFG_FAILURE_LIMIT: trk_cfg.failure_limit         = cfg_wdata[3:0];
                    default:           ;
                endcase
            end

            // compare a result transfer with the oldest pending report
            if (m_tvalid && m_tready)
            begin
                got = result_t'(m_tdata[20:0]);
                if (lock_reports_due.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display("%0t: unexpected report code %0d usable %0b hide %0b batches %0d",
                                 $realtime, got.lock_code, got.trusted_usable,
                                 got.hide_markers, got.failed_batch_count);
                end
                else
                begin
                    want = lock_reports_due.pop_front();
                    reports_checked++;
                    if (got.lock_code !== want.lock_code ||
                        got.trusted_usable !== want.trusted_usable ||
                        got.hide_markers !== want.hide_markers ||
                        got.failed_batch_count !== want.failed_batch_count)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_REPORTS)
                            $display("%0t: report %0d: exp code %0d usable %0b hide %0b batches %0d, got code %0d usable %0b hide %0b batches %0d",
                                     $realtime, reports_checked,
                                     want.lock_code, want.trusted_usable,
                                     want.hide_markers, want.failed_batch_count,
                                     got.lock_code, got.trusted_usable,
                                     got.hide_markers, got.failed_batch_count);
                    end
                end
            end

            // predict the report for each accepted event
            if (s_tvalid && s_tready)
            begin
                ev   = lock_event_t'(s_tdata[35:0]);
                want = advance_tracker(ev);
                lock_reports_due.push_back(want);
                states_seen[want.lock_code] = 1'b1;
            end

            // receiver: mostly ready, short stalls, the odd long one
            if (steady)
                m_tready <= 1'b1;
            else if (stall_left > 0)
            begin
                stall_left--;
                m_tready <= 1'b0;
            end
            else
            begin
                pick = $urandom_range(0, 99);
                if (pick < 60)
                    m_tready <= 1'b1;
                else
                begin
                    stall_left = (pick < 92) ? $urandom_range(0, 2) : $urandom_range(7, 40);
                    m_tready <= 1'b0;
                end
            end
        end
    end

    // Watchdog: end the run if no transfer happens on either stream for too long
    always @(posedge clk)
    begin
        if (rst_n && !((s_tvalid && s_tready) || (m_tvalid && m_tready)))
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles, %0d reports still pending",
                         $realtime, idle_cycles, lock_reports_due.size());
                $display("tracking_lock_state_machine verification failed");
                $finish;
            end
        end
        else
            idle_cycles = 0;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic int pick_gap();
        int r;
        if (steady)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Timestamps: mostly a clock moving forward, some right at the hold edge,
    // some anywhere, some just behind the trusted time
    function automatic logic [31:0] pick_stamp();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60)
            clock_ms = clock_ms + $urandom_range(0, int'(trk_cfg.hold_time_ms) / 3 + 1);
        else if (r < 75)
            clock_ms = trust_time + {16'd0, trk_cfg.hold_time_ms} + $urandom_range(0, 2) - 1;
        else if (r < 85)
            clock_ms = $urandom;
        else if (r < 92)
            clock_ms = trust_time - $urandom_range(1, 3);
        return clock_ms;
    endfunction

    // Send one event; hold tvalid high across back-to-back transfers
    task automatic send_event(logic [2:0] op, logic vis, logic [31:0] stamp);
        int          gap;
        lock_event_t ev;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        ev.op      = op;
        ev.visible = vis;
        ev.now_ms  = stamp;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, ev};
        do
            @(posedge clk);
        while (!s_tready);
        events_sent++;
    endtask

    // Drop tvalid and wait until every pending report has come back
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (lock_reports_due.size() != 0)
            @(posedge clk);
    endtask

    // Write all three registers on consecutive cycles; call only when drained
    task automatic load_settings(logic [15:0] hold, logic [15:0] need_word,
                                 logic [15:0] limit_word);
        cfg_wen   <= 1'b1;
        cfg_index <= CFG_HOLD_TIME;
        cfg_wdata <= hold;
        @(posedge clk);
        cfg_index <= CFG_VISIBLE_NEED;
        cfg_wdata <= need_word;
        @(posedge clk);
        cfg_index <= CFG_FAILURE_LIMIT;
        cfg_wdata <= limit_word;
        @(posedge clk);
        cfg_wen <= 1'b0;
        settings_loaded++;
    endtask

    // Walk the whole machine once under the current settings
    task automatic walk_machine(logic [31:0] base);
        logic [31:0] hold;
        hold = {16'd0, trk_cfg.hold_time_ms};
        send_event(OP_RESET, 1'b0, base);
        send_event(OP_VISIBILITY, 1'b0, base);
        // more visible frames than the count can hold
        repeat (17) send_event(OP_VISIBILITY, 1'b1, base + 32'd1);
        send_event(OP_RECOG_OK, 1'b1, base + 32'd2);
        send_event(OP_QUERY, 1'b0, base + 32'd2 + hold);
        send_event(OP_QUERY, 1'b1, base + 32'd3 + hold);
        repeat (17) send_event(OP_CONT_FAIL, 1'b0, base + 32'd4);
        send_event(OP_CONT_OK, 1'b0, base + 32'd5);
        send_event(OP_CONT_FAIL, 1'b1, base + 32'd5);
        send_event(OP_RESTART, 1'b0, base + 32'd6);
        send_event(OP_QUERY, 1'b0, base + 32'd6);
    endtask

    // One stretch of random traffic: mostly a proper acquire-and-track sequence
    task automatic run_episode();
        int kind;
        int n;
        int r;
        int fail_pct;
        kind = $urandom_range(0, 99);
        if (kind < 70)
        begin
            if ($urandom_range(0, 1))
                send_event(OP_VISIBILITY, 1'b0, pick_stamp());
            n = int'(trk_cfg.visible_frames_needed) + $urandom_range(0, 2);
            repeat (n) send_event(OP_VISIBILITY, 1'b1, pick_stamp());
            n = $urandom_range(0, 3);
            repeat (n) send_event(OP_RECOG_FAIL, 1'($urandom), pick_stamp());
            send_event($urandom_range(0, 1) ? OP_RECOG_OK : OP_CONT_OK, 1'($urandom),
                       pick_stamp());
            n        = $urandom_range(3, 12);
            fail_pct = $urandom_range(20, 90);
            repeat (n)
            begin
                r = $urandom_range(0, 99);
                if (r < fail_pct)
                    send_event(OP_CONT_FAIL, 1'($urandom), pick_stamp());
                else if (r < fail_pct + (100 - fail_pct) / 2)
                    send_event(OP_CONT_OK, 1'($urandom), pick_stamp());
                else
                    send_event(OP_QUERY, 1'($urandom), pick_stamp());
            end
        end
        else
        begin
            // noise: any op, any flag, any time
            n = $urandom_range(1, 8);
            repeat (n) send_event(3'($urandom_range(0, 7)), 1'($urandom), pick_stamp());
        end
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_reset_defaults();
        send_event(OP_QUERY, 1'b0, 32'd0);
        send_event(OP_VISIBILITY, 1'b0, 32'd10);           // hidden
        send_event(OP_VISIBILITY, 1'b1, 32'd20);           // back to uninit, one frame
        send_event(OP_VISIBILITY, 1'b1, 32'd30);           // second frame: recovering
        send_event(OP_CONT_FAIL, 1'b0, 32'd40);            // ignored outside tracking/suspect
        send_event(OP_RECOG_OK, 1'b1, 32'd1000);
        send_event(OP_QUERY, 1'b0, 32'd3000);              // exactly the hold time
        send_event(OP_QUERY, 1'b0, 32'd3001);              // one past it
        send_event(OP_CONT_FAIL, 1'b0, 32'd3001);          // suspect without usable position
        send_event(OP_CONT_OK, 1'b0, 32'd3500);
        send_event(OP_CONT_FAIL, 1'b0, 32'd3600);
        send_event(OP_CONT_FAIL, 1'b0, 32'd3700);
        send_event(OP_CONT_FAIL, 1'b0, 32'd3800);          // failure limit: recovering
        send_event(OP_VISIBILITY, 1'b1, 32'd3900);         // visible outside uninit: no change
        send_event(OP_RECOG_FAIL, 1'b0, 32'd4000);
        send_event(OP_RECOG_FAIL, 1'b1, 32'd4100);
        send_event(OP_VISIBILITY, 1'b0, 32'd4200);
        send_event(OP_QUERY, 1'b0, 32'd4200);              // hidden never usable
        send_event(OP_RECOG_OK, 1'b0, 32'hFFFF_FF00);
        send_event(OP_QUERY, 1'b0, 32'h0000_0100);         // time wraps past zero
        send_event(OP_QUERY, 1'b0, 32'hFFFF_FEFF);         // time runs backwards
        send_event(OP_RESTART, 1'b1, 32'hFFFF_FFFF);
        send_event(OP_QUERY, 1'b0, 32'hFFFF_FFFF);
        send_event(OP_RESET, 1'b0, 32'h5555_AAAA);
        send_event(OP_QUERY, 1'b1, 32'hAAAA_5555);
    endtask

    task automatic test_register_extremes();
        drain();
        load_settings(16'h0000, 16'h0001, 16'h0001);
        walk_machine(32'h0000_1000);
        drain();
        load_settings(16'hFFFF, 16'h000F, 16'h000F);
        walk_machine(32'hFFFF_FFF8);
        // upper bits of the 4-bit registers are dropped, leaving zero thresholds
        drain();
        load_settings(16'h0001, 16'hFFF0, 16'hFFF0);
        walk_machine(32'h7FFF_FFF0);
    endtask

    task automatic test_random_traffic();
        int          phase_start;
        logic [15:0] hold;
        logic [15:0] need_word;
        logic [15:0] limit_word;
        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            drain();
            case (phase)
                0:       hold = 16'h0000;
                1:       hold = 16'hFFFF;
                5:       hold = 16'($urandom);
                default: hold = 16'($urandom_range(1, 3000));
            endcase
            // small thresholds get deep into the machine; junk in the upper bits
            need_word  = (16'($urandom) & 16'hFFF0) |
                         16'((phase == 5) ? $urandom_range(0, 15) : $urandom_range(1, 4));
            limit_word = (16'($urandom) & 16'hFFF0) |
                         16'((phase == 5) ? $urandom_range(0, 15) : $urandom_range(1, 4));
            load_settings(hold, need_word, limit_word);
            phase_start = events_sent;
            while (events_sent - phase_start < ITEMS_PER_PHASE)
            begin
                // every so often run a stretch with no gaps on either side
                steady = ($urandom_range(0, 99) < 20);
                run_episode();
            end
            steady = 1'b0;
        end
    endtask

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_defaults();
        test_register_extremes();
        test_random_traffic();

        // hold until every report is back, then check that none is left pending
        drain();
        repeat (4) @(posedge clk);
        if (lock_reports_due.size() != 0)
        begin
            $display("%0d reports never arrived", lock_reports_due.size());
            mismatches += lock_reports_due.size();
        end

        $display("Sent %0d events under %0d register settings, checked %0d reports.",
                 events_sent, settings_loaded + 1, reports_checked);
        $display("Lock codes reached (one bit per code): %05b; mismatches: %0d.",
                 states_seen, mismatches);
        if (mismatches == 0)
            $display("tracking_lock_state_machine verification clean");
        else
            $display("tracking_lock_state_machine verification failed");
        $finish;
    end

endmodule
